// File: hdl/assert_macros.svh
// assertion macros used by the checker file
// clocked on clk, disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RNDC_AST_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rndc check failed");

// next-cycle implication
`define RNDC_AST_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rndc check failed");

`endif

// File: hdl/rndc_pkg.sv
// types and constants of the radius neighbor density counter
// no dependencies; used by the top level and its checker
`default_nettype none

package rndc_pkg;

  localparam int SLOT_W      = 10;
  localparam int IN_COORD_W  = 31;
  localparam int COUNT_W     = 11;
  localparam int LEVEL_W     = 8;
  localparam int RADIUS_W    = 63;
  localparam int SUM_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [COUNT_W-1:0]  COUNT_MAX       = 11'd2047;
  localparam logic [COUNT_W-1:0]  NUM_BODIES_RST  = 11'd800;
  localparam logic [RADIUS_W-1:0] RADIUS_SQ_RST   = 63'd1278992169;
  localparam logic [LEVEL_W-1:0]  FULL_SCALE_RST  = 8'd15;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BODIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd2;

  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REDUCE = 5'b00010,
    ST_QPOS   = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_DRAIN  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// File: hdl/radius_neighbor_density_count.sv
// Fixed-radius neighbor counter over a store of 3D body positions.
// Command channel: start/busy; an item is taken at a clock edge with start high and
// busy low. action selects a store (write pos_x/y/z into slot) or a query of slot.
// Slots at or above MAX_BODIES are first reduced by repeated subtraction of
// MAX_BODIES, one subtraction per cycle.
// A store gives no result.
// A query scans L = min(num_bodies, MAX_BODIES) stored bodies through one shared
// squarer, one axis per cycle; the result shows on done for one cycle, rising at
// the same clock edge at which busy falls.
// The result beat (queried_slot, neighbor_count, level, saturated) is valid only
// while done is high; the receiver cannot stall it.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready,
// to be written only while the block is idle.
// Reset (rst, synchronous) returns the sequencer to idle and loads the default
// config; the position store is not cleared and must be written before use.
// Depends on rndc_pkg.
`default_nettype none

module radius_neighbor_density_count
  import rndc_pkg::*;
#(
  parameter int MAX_BODIES  = 1024,
  parameter int COORD_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         action,
  input  logic [SLOT_W-1:0]            slot,
  input  logic signed [IN_COORD_W-1:0] pos_x,
  input  logic signed [IN_COORD_W-1:0] pos_y,
  input  logic signed [IN_COORD_W-1:0] pos_z,
  output logic                         done,
  output logic [SLOT_W-1:0]            queried_slot,
  output logic [COUNT_W-1:0]           neighbor_count,
  output logic [LEVEL_W-1:0]           level,
  output logic                         saturated,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int IDX_W   = $clog2(MAX_BODIES);
  localparam int ENTRY_W = 3 * COORD_WIDTH;
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int SQ_W    = (DIFF_W < 32) ? DIFF_W : 32;
  localparam int LIM_W   = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;

  state_t state, state_next;

  logic [COUNT_W-1:0]  num_bodies;
  logic [RADIUS_W-1:0] radius_squared;
  logic [LEVEL_W-1:0]  full_scale;

  logic                act_q;
  logic [SLOT_W-1:0]   slot_r;
  logic [ENTRY_W-1:0]  wr_data;

  logic [ENTRY_W-1:0]  mem [MAX_BODIES];
  logic [ENTRY_W-1:0]  rd_q;
  logic [ENTRY_W-1:0]  qpos;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                mem_we;

  logic [IDX_W-1:0]    j;
  logic [1:0]          ax;

  logic                s1_vld, s1_first, s1_last;
  logic [SQ_W-1:0]     mag_q;
  logic                s2_vld, s2_first, s2_last;
  logic [2*SQ_W-1:0]   sq_q;
  logic [SUM_W-1:0]    acc;
  logic [COUNT_W-1:0]  count;

  logic                slot_big;
  logic [LIM_W-1:0]    nb_ext, limit;
  logic                last_body;
  logic signed [COORD_WIDTH-1:0] coord_a, coord_b;
  logic signed [DIFF_W-1:0]      diff;
  logic [DIFF_W-1:0]             mag_full;
  logic [SUM_W-1:0]    sum;
  logic                hit;
  logic [LEVEL_W-1:0]  lvl;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign slot_big  = (32'(slot_r) >= 32'(MAX_BODIES));
  assign nb_ext    = LIM_W'(num_bodies);
  assign limit     = (nb_ext > LIM_W'(MAX_BODIES)) ? LIM_W'(MAX_BODIES) : nb_ext;
  assign last_body = ((LIM_W'(j) + LIM_W'(1)) == limit);

  // one axis of the queried body against one axis of the scanned body
  assign coord_a  = qpos[ax*COORD_WIDTH +: COORD_WIDTH];
  assign coord_b  = rd_q[ax*COORD_WIDTH +: COORD_WIDTH];
  assign diff     = DIFF_W'(coord_a) - DIFF_W'(coord_b);
  assign mag_full = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  assign sum = (s2_first ? '0 : acc) + SUM_W'(sq_q);
  assign hit = (sum < SUM_W'(radius_squared));
  assign lvl = (count < COUNT_W'(full_scale)) ? count[LEVEL_W-1:0] : full_scale;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (!slot_big) state_next = (act_q == ACT_STORE) ? ST_IDLE : ST_QPOS;
      end
      ST_QPOS: begin
        state_next = (limit == '0) ? ST_DRAIN : ST_SCAN;
      end
      ST_SCAN: begin
        if (ax == AX_Z && last_body) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!s1_vld && !s2_vld) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    mem_we  = 1'b0;
    case (state)
      ST_REDUCE: begin
        if (!slot_big) begin
          if (act_q == ACT_STORE) begin
            mem_we = 1'b1;
          end else begin
            rd_en = 1'b1;
          end
          rd_addr = IDX_W'(slot_r);
        end
      end
      ST_QPOS: begin
        rd_en = 1'b1;
      end
      ST_SCAN: begin
        if (ax == AX_Z && !last_body) begin
          rd_en   = 1'b1;
          rd_addr = j + IDX_W'(1);
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // position store
  always_ff @(posedge clk) begin
    if (mem_we) mem[rd_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_bodies     <= NUM_BODIES_RST;
      radius_squared <= RADIUS_SQ_RST;
      full_scale     <= FULL_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_BODIES: num_bodies     <= cfg_data[COUNT_W-1:0];
        CFG_RADIUS_SQ:  radius_squared <= cfg_data[RADIUS_W-1:0];
        CFG_FULL_SCALE: full_scale     <= cfg_data[LEVEL_W-1:0];
        default:        ;
      endcase
    end
  end

  // sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      s1_vld <= (state == ST_SCAN);
      s2_vld <= s1_vld;
      done   <= (state == ST_DRAIN) && !s1_vld && !s2_vld;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      act_q   <= action;
      slot_r  <= slot;
      wr_data <= {COORD_WIDTH'(pos_z), COORD_WIDTH'(pos_y), COORD_WIDTH'(pos_x)};
    end
    if (state == ST_REDUCE && slot_big) begin
      slot_r <= slot_r - SLOT_W'(MAX_BODIES);
    end
    if (state == ST_QPOS) begin
      qpos  <= rd_q;
      j     <= '0;
      ax    <= AX_X;
      count <= '0;
    end
    if (state == ST_SCAN) begin
      if (ax == AX_Z) begin
        ax <= AX_X;
        if (!last_body) j <= j + IDX_W'(1);
      end else begin
        ax <= ax + 2'd1;
      end
    end
    // stage 1: magnitude of one axis difference
    s1_first <= (ax == AX_X);
    s1_last  <= (ax == AX_Z);
    mag_q    <= mag_full[SQ_W-1:0];
    // stage 2: shared squarer
    s2_first <= s1_first;
    s2_last  <= s1_last;
    sq_q     <= mag_q * mag_q;
    // stage 3: accumulate, compare on the last axis
    if (s2_vld) begin
      acc <= sum;
      if (s2_last && hit && count < COUNT_MAX) count <= count + COUNT_W'(1);
    end
    if (state == ST_DRAIN && !s1_vld && !s2_vld) begin
      queried_slot   <= slot_r;
      neighbor_count <= count;
      level          <= lvl;
      saturated      <= (count >= COUNT_W'(full_scale));
    end
  end

endmodule

`default_nettype wire

// File: hdl/rndc_checker.sv
// port-level checks for radius_neighbor_density_count, bound to the top level
// depends on rndc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rndc_checker
  import rndc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  done,
  input wire logic [COUNT_W-1:0]    neighbor_count,
  input wire logic [LEVEL_W-1:0]    level,
  input wire logic                  saturated,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [LEVEL_W-1:0] fs_shadow;

  // tracks the full scale written through the config port
  always_ff @(posedge clk) begin
    if (rst) begin
      fs_shadow <= FULL_SCALE_RST;
    end else if (cfg_valid && cfg_ready && cfg_index == CFG_FULL_SCALE) begin
      fs_shadow <= cfg_data[LEVEL_W-1:0];
    end
  end

  `RNDC_AST_NEXT(a_accept_busy, start && !busy, busy)
  `RNDC_AST_NEXT(a_done_pulse, done, !done)
  `RNDC_AST_IMPL(a_level_le_count, done, COUNT_W'(level) <= neighbor_count)
  `RNDC_AST_IMPL(a_sat_match, done, saturated == (neighbor_count >= COUNT_W'(fs_shadow)))

endmodule

bind radius_neighbor_density_count rndc_checker u_rndc_checker (.*);

`default_nettype wire

// File: bench/tb_top.sv
// self-checking bench for radius_neighbor_density_count: fills the low slots of the
// position store, then drives directed and random store/query beats and compares each
// count result against an in-bench neighbor counter; depends on rndc_pkg and the rtl
`timescale 1ns / 100ps

module tb_top;
  import rndc_pkg::*;

  localparam int NUM_SLOTS = 1024;
  localparam int FILL_SLOTS = 128;
  localparam int NUM_CENTERS = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef logic signed [IN_COORD_W-1:0] coord_t;
  localparam coord_t COORD_MIN = {1'b1, {(IN_COORD_W-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(IN_COORD_W-1){1'b1}}};

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } body_t;

  typedef struct {
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
    logic [LEVEL_W-1:0] level;
    logic               sat;
  } density_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  action = ACT_STORE;
  logic [SLOT_W-1:0]     slot = '0;
  coord_t                pos_x = '0;
  coord_t                pos_y = '0;
  coord_t                pos_z = '0;
  logic                  done;
  logic [SLOT_W-1:0]     queried_slot;
  logic [COUNT_W-1:0]    neighbor_count;
  logic [LEVEL_W-1:0]    level;
  logic                  saturated;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // bench copy of the block's registers and position store
  logic [COUNT_W-1:0]  cfg_bodies = NUM_BODIES_RST;
  logic [RADIUS_W-1:0] cfg_radius_sq = RADIUS_SQ_RST;
  logic [LEVEL_W-1:0]  cfg_full_scale = FULL_SCALE_RST;
  longint              body_pos [NUM_SLOTS][3];
  bit                  slot_written [NUM_SLOTS];
  coord_t              centers [NUM_CENTERS][3];

  density_t density_q [$];

  bit steady = 1'b0;
  int n_errors = 0;
  int n_stores = 0;
  int n_queries = 0;
  int n_cfg_writes = 0;
  int n_results = 0;
  int n_saturated = 0;

  radius_neighbor_density_count u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .slot           (slot),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .done           (done),
    .queried_slot   (queried_slot),
    .neighbor_count (neighbor_count),
    .level          (level),
    .saturated      (saturated),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // counts stored bodies strictly inside the radius around slot s
  function automatic density_t count_neighbors(input logic [SLOT_W-1:0] s);
    density_t    r;
    int unsigned lim;
    int unsigned cnt;
    int unsigned j;
    int unsigned k;
    longint      diff;
    bit [63:0]   d;
    bit [63:0]   dist_sq;
    lim = (cfg_bodies > NUM_SLOTS) ? NUM_SLOTS : cfg_bodies;
    cnt = 0;
    for (j = 0; j < lim; j++) begin
      dist_sq = '0;
      for (k = 0; k < 3; k++) begin
        diff = body_pos[s][k] - body_pos[j][k];
        d = (diff < 0) ? -diff : diff;
        dist_sq += d * d;
      end
      if (dist_sq < {1'b0, cfg_radius_sq} && cnt < COUNT_MAX) cnt++;
    end
    r.slot = s;
    r.count = cnt[COUNT_W-1:0];
    r.level = (cnt < cfg_full_scale) ? cnt[LEVEL_W-1:0] : cfg_full_scale;
    r.sat = (cnt >= cfg_full_scale);
    return r;
  endfunction

  function automatic coord_t near(input coord_t c);
    int v;
    v = int'(c) + int'($urandom_range(65535)) - 32768;
    return coord_t'(v);
  endfunction

  // mostly clustered around a few centers so counts spread out
  function automatic body_t make_body();
    body_t b;
    int    ctr;
    if ($urandom_range(5) == 0) begin
      b.x = coord_t'($urandom);
      b.y = coord_t'($urandom);
      b.z = coord_t'($urandom);
    end else begin
      ctr = $urandom_range(NUM_CENTERS - 1);
      b.x = near(centers[ctr][0]);
      b.y = near(centers[ctr][1]);
      b.z = near(centers[ctr][2]);
    end
    return b;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_item(input logic act, input logic [SLOT_W-1:0] s, input body_t p);
    int gap;
    if (!steady && $urandom_range(99) < 13) begin
      gap = $urandom_range(1, ($urandom_range(3) == 0) ? 40 : 4);
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    action = act;
    slot = s;
    pos_x = p.x;
    pos_y = p.y;
    pos_z = p.z;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (act == ACT_STORE) begin
      body_pos[s][0] = longint'(p.x);
      body_pos[s][1] = longint'(p.y);
      body_pos[s][2] = longint'(p.z);
      slot_written[s] = 1'b1;
      n_stores++;
    end else begin
      density_q.push_back(count_neighbors(s));
      n_queries++;
    end
    @(negedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes keep it steady
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_NUM_BODIES: cfg_bodies = data[COUNT_W-1:0];
      CFG_RADIUS_SQ:  cfg_radius_sq = data[RADIUS_W-1:0];
      CFG_FULL_SCALE: cfg_full_scale = data[LEVEL_W-1:0];
      default: ;
    endcase
    n_cfg_writes++;
    @(negedge clk);
  endtask

  // unused upper data bits carry random junk
  task automatic configure(input logic [COUNT_W-1:0] nb, input logic [RADIUS_W-1:0] rad,
                           input logic [LEVEL_W-1:0] fs);
    logic [CFG_DATA_W-1:0] d;
    d = {$urandom, $urandom};
    d[COUNT_W-1:0] = nb;
    write_reg(CFG_NUM_BODIES, d);
    d = {$urandom, $urandom};
    d[RADIUS_W-1:0] = rad;
    write_reg(CFG_RADIUS_SQ, d);
    d = {$urandom, $urandom};
    d[LEVEL_W-1:0] = fs;
    write_reg(CFG_FULL_SCALE, d);
    cfg_valid = 1'b0;
  endtask

  // stores give no result, so also let a trailing store finish
  task automatic wait_idle();
    start = 1'b0;
    while (density_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic test_fill_store();
    body_t p;
    int    c;
    int    a;
    int    i;
    for (c = 0; c < NUM_CENTERS; c++)
      for (a = 0; a < 3; a++)
        centers[c][a] = coord_t'(int'($urandom_range(0, 1 << 30)) - (1 << 29));
    for (i = 0; i < FILL_SLOTS; i++) begin
      p = make_body();
      if (i == 0) p = {COORD_MIN, COORD_MIN, COORD_MIN};
      if (i == 1) p = {COORD_MAX, COORD_MIN, coord_t'(0)};
      send_item(ACT_STORE, SLOT_W'(i), p);
    end
    send_item(ACT_STORE, SLOT_W'(NUM_SLOTS - 1), {COORD_MAX, COORD_MAX, COORD_MAX});
  endtask

  // default radius and full scale over the filled slots; the last slot lies outside
  task automatic test_reset_defaults();
    wait_idle();
    write_reg(CFG_NUM_BODIES, CFG_DATA_W'(FILL_SLOTS));
    cfg_valid = 1'b0;
    send_item(ACT_QUERY, SLOT_W'(0), make_body());
    send_item(ACT_QUERY, SLOT_W'(5), make_body());
    send_item(ACT_QUERY, SLOT_W'(NUM_SLOTS - 1), make_body());
  endtask

  task automatic test_extreme_config();
    wait_idle();
    // opposite corners are farther apart than the largest radius allows
    configure(COUNT_W'(FILL_SLOTS), '1, 8'd255);
    send_item(ACT_QUERY, SLOT_W'(0), make_body());
    send_item(ACT_QUERY, SLOT_W'(NUM_SLOTS - 1), make_body());
    send_item(ACT_QUERY, SLOT_W'($urandom_range(FILL_SLOTS - 1)), make_body());
    wait_idle();
    // wide radius over the whole filled range
    configure(COUNT_W'(FILL_SLOTS), 63'd1 << 40, 8'd255);
    send_item(ACT_QUERY, SLOT_W'(64), make_body());
    wait_idle();
    configure(11'd0, '1, 8'd0);
    send_item(ACT_QUERY, SLOT_W'(7), make_body());
    wait_idle();
    configure(11'd1, 63'd0, 8'd1);
    send_item(ACT_QUERY, SLOT_W'(0), make_body());
    wait_idle();
    configure(11'd5, '1, 8'd0);
    send_item(ACT_QUERY, SLOT_W'(3), make_body());
  endtask

  // distance squared exactly equal to the radius is not a neighbor
  task automatic test_boundary_cases();
    wait_idle();
    write_reg(CFG_UNUSED, {$urandom, $urandom});
    configure(11'd3, 63'd25, 8'd2);
    send_item(ACT_STORE, SLOT_W'(0), {coord_t'(0), coord_t'(0), coord_t'(0)});
    send_item(ACT_STORE, SLOT_W'(1), {coord_t'(3), coord_t'(4), coord_t'(0)});
    send_item(ACT_STORE, SLOT_W'(2), {coord_t'(-3), coord_t'(-4), coord_t'(0)});
    send_item(ACT_QUERY, SLOT_W'(0), make_body());
    wait_idle();
    configure(11'd3, 63'd26, 8'd2);
    send_item(ACT_QUERY, SLOT_W'(0), make_body());
    send_item(ACT_QUERY, SLOT_W'(1), make_body());
    wait_idle();
    configure(11'd3, 63'd101, 8'd3);
    send_item(ACT_QUERY, SLOT_W'(2), make_body());
  endtask

  task automatic test_random_traffic();
    logic [COUNT_W-1:0]  nb;
    logic [RADIUS_W-1:0] rad;
    logic [LEVEL_W-1:0]  fs;
    logic [SLOT_W-1:0]   s;
    int                  ph;
    int                  i;
    for (ph = 0; ph < 12; ph++) begin
      nb = (ph % 4 == 3) ? COUNT_W'($urandom_range(1, 3)) : COUNT_W'($urandom_range(4, 64));
      case ($urandom_range(5))
        0: rad = '0;
        1: rad = '1;
        2: rad = RADIUS_W'({$urandom, $urandom});
        default: rad = RADIUS_W'($urandom) << $urandom_range(0, 4);
      endcase
      case ($urandom_range(3))
        0: fs = '0;
        1: fs = '1;
        2: fs = LEVEL_W'($urandom_range(1, 12));
        default: fs = LEVEL_W'($urandom);
      endcase
      wait_idle();
      configure(nb, rad, fs);
      steady = (ph == 4 || ph == 5);
      for (i = 0; i < 36; i++) begin
        if ($urandom_range(99) < 40) begin
          s = ($urandom_range(3) != 0) ? SLOT_W'($urandom_range(nb - 1)) : SLOT_W'($urandom);
          send_item(ACT_STORE, s, make_body());
        end else begin
          s = $urandom_range(1) ? SLOT_W'($urandom_range(nb - 1)) : SLOT_W'($urandom);
          // only query slots that hold a position
          if (!slot_written[s]) s = SLOT_W'($urandom_range(nb - 1));
          send_item(ACT_QUERY, s, make_body());
        end
      end
    end
    steady = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    density_t want;
    if (!rst && done) begin
      if (density_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result beat, expected none, actual slot %0d count %0d",
                 $time, queried_slot, neighbor_count);
      end else begin
        want = density_q.pop_front();
        n_results++;
        if (saturated === 1'b1) n_saturated++;
        check_field("queried_slot", 16'(want.slot), 16'(queried_slot));
        check_field("neighbor_count", 16'(want.count), 16'(neighbor_count));
        check_field("level", 16'(want.level), 16'(level));
        check_field("saturated", 16'(want.sat), 16'(saturated));
      end
    end
  end

  initial begin
    int guard;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_fill_store();
    test_reset_defaults();
    test_extreme_config();
    test_boundary_cases();
    test_random_traffic();
    start = 1'b0;
    guard = 0;
    while (density_q.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    if (density_q.size() != 0) begin
      n_errors++;
      $display("%0t: %0d count results never arrived", $time, density_q.size());
    end
    repeat (20) @(negedge clk);
    $display("run covered %0d stores, %0d queries and %0d register writes",
             n_stores, n_queries, n_cfg_writes);
    $display("%0d count results checked, %0d of them saturated", n_results, n_saturated);
    if (n_errors == 0) begin
      $display("radius_neighbor_density_count test passed");
    end else begin
      $display("radius_neighbor_density_count test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("radius_neighbor_density_count test failed");
    $finish;
  end

endmodule
